// ===== sv/max_pool_2d_argmax_top_macros.svh =====
// Assertion macros for the max pooling block and its port checker.
// Depends on a clock named aclk and an active-low reset named aresetn in the user's scope.
`ifndef MAX_POOL_2D_ARGMAX_TOP_MACROS_SVH
`define MAX_POOL_2D_ARGMAX_TOP_MACROS_SVH

// Checked only while out of reset.
`define MPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define MPA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/mpa_pkg.sv =====
// Shared constants and types of the max pooling block with argmax.
// No dependencies; the design files refer to it by scoped names.
package mpa_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_WINDOW_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int IDX_BITS        = 20;
    localparam int WIDTH_CFG_BITS  = 11;
    localparam int WINDOW_CFG_BITS = 4;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE = CFG_INDEX_BITS'(1);

    localparam logic [WIDTH_CFG_BITS-1:0]  WIDTH_RESET  = WIDTH_CFG_BITS'(32);
    localparam logic [WINDOW_CFG_BITS-1:0] WINDOW_RESET = WINDOW_CFG_BITS'(2);

    // Per-item control flags that travel alongside the payload.
    typedef struct packed {
        logic active;     // pixel lies inside a whole window
        logic first_pix;  // first pixel of its window
        logic emit;       // last pixel of its window
        logic last;       // window is the last of the image
    } item_ctl_t;

endpackage

// ===== sv/mpa_ctrl.sv =====
// Raster position tracking, configuration registers and window entry addressing.
// Depends on mpa_pkg.
module mpa_ctrl #(
    parameter int MAX_WIDTH  = mpa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = mpa_pkg::MAX_WINDOW_DEF,
    localparam int PW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int KW = $clog2(MAX_WINDOW + 1),
    localparam int RW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mpa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mpa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                item_valid,
    input  logic                                item_first,
    input  logic                                en,
    output logic                                accept,
    output mpa_pkg::item_ctl_t                  ctl,
    output logic [PW-1:0]                       addr,
    output logic [RW-1:0]                       cin,
    output logic [RW-1:0]                       rin,
    output logic [PW-1:0]                       base_row,
    output logic [PW-1:0]                       base_col,
    output logic [mpa_pkg::IDX_BITS-1:0]        pooled,
    output logic [WW-1:0]                       w_eff
);

    localparam int WCW = (WW > mpa_pkg::WIDTH_CFG_BITS) ? WW : mpa_pkg::WIDTH_CFG_BITS;
    localparam int KCW = (KW > mpa_pkg::WINDOW_CFG_BITS) ? KW : mpa_pkg::WINDOW_CFG_BITS;
    localparam int EW  = WW + 6;

    logic [mpa_pkg::WIDTH_CFG_BITS-1:0]  width_cfg_reg;
    logic [mpa_pkg::WINDOW_CFG_BITS-1:0] window_cfg_reg;

    logic [PW-1:0]                pixel_col_reg, pixel_col_next;
    logic [PW-1:0]                pixel_row_reg, pixel_row_next;
    logic [RW-1:0]                col_in_win_reg, col_in_win_next;
    logic [RW-1:0]                row_in_win_reg, row_in_win_next;
    logic [PW-1:0]                window_col_reg, window_col_next;
    logic [mpa_pkg::IDX_BITS-1:0] pooled_count_reg, pooled_count_next;

    logic [WCW-1:0] width_ext;
    logic [KCW-1:0] window_ext;
    logic [KW-1:0]  k_eff;
    logic [KW-1:0]  k_m1;

    logic [PW-1:0]                pc_c, pr_c, wc_c;
    logic [RW-1:0]                cin_c, rin_c;
    logic [mpa_pkg::IDX_BITS-1:0] pooled_c;
    logic [PW-1:0]                col_start, row_start;
    logic                         col_fit, row_fit, col_lastw, row_lastw;

    assign cfg_ready = 1'b1;

    // Clamp the registers into their working ranges.
    always_comb begin
        width_ext  = WCW'(width_cfg_reg);
        window_ext = KCW'(window_cfg_reg);
        if (width_ext == '0) begin
            w_eff = WW'(1);
        end else if (width_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_ext);
        end
        if (window_ext == '0) begin
            k_eff = KW'(1);
        end else if (window_ext > KCW'(MAX_WINDOW)) begin
            k_eff = KW'(MAX_WINDOW);
        end else begin
            k_eff = KW'(window_ext);
        end
        k_m1 = k_eff - KW'(1);
    end

    // Current position, with a frame start forcing the counters to zero.
    always_comb begin
        if (item_first) begin
            pc_c     = '0;
            pr_c     = '0;
            wc_c     = '0;
            cin_c    = '0;
            rin_c    = '0;
            pooled_c = '0;
        end else begin
            pc_c     = pixel_col_reg;
            pr_c     = pixel_row_reg;
            wc_c     = window_col_reg;
            cin_c    = col_in_win_reg;
            rin_c    = row_in_win_reg;
            pooled_c = pooled_count_reg;
        end
    end

    // A window fits when its start plus the window side stays within the image.
    assign col_start = pc_c - PW'(cin_c);
    assign row_start = pr_c - PW'(rin_c);
    assign col_fit   = (EW'(col_start) + EW'(k_eff)) <= EW'(w_eff);
    assign row_fit   = (EW'(row_start) + EW'(k_eff)) <= EW'(w_eff);
    assign col_lastw = (EW'(col_start) + EW'({k_eff, 1'b0})) > EW'(w_eff);
    assign row_lastw = (EW'(row_start) + EW'({k_eff, 1'b0})) > EW'(w_eff);

    assign accept        = item_valid && en;
    assign ctl.active    = col_fit && row_fit;
    assign ctl.first_pix = (cin_c == '0) && (rin_c == '0);
    assign ctl.emit      = (KW'(cin_c) == k_m1) && (KW'(rin_c) == k_m1);
    assign ctl.last      = col_lastw && row_lastw;
    assign addr          = wc_c;
    assign cin           = cin_c;
    assign rin           = rin_c;
    assign base_row      = row_start;
    assign base_col      = col_start;
    assign pooled        = pooled_c;

    always_comb begin
        logic [KW-1:0] cin_inc;
        logic [KW-1:0] rin_inc;
        logic [WW-1:0] pc_inc;
        logic [WW-1:0] pr_inc;
        cin_inc           = KW'(cin_c) + KW'(1);
        rin_inc           = KW'(rin_c) + KW'(1);
        pc_inc            = WW'(pc_c) + WW'(1);
        pr_inc            = WW'(pr_c) + WW'(1);
        pixel_row_next    = pr_c;
        row_in_win_next   = rin_c;
        pooled_count_next = pooled_c + mpa_pkg::IDX_BITS'(ctl.active && ctl.emit);
        if (cin_inc >= k_eff) begin
            col_in_win_next = '0;
            window_col_next = wc_c + PW'(1);
        end else begin
            col_in_win_next = RW'(cin_inc);
            window_col_next = wc_c;
        end
        if (pc_inc >= w_eff) begin
            pixel_col_next  = '0;
            col_in_win_next = '0;
            window_col_next = '0;
            row_in_win_next = (rin_inc >= k_eff) ? '0 : RW'(rin_inc);
            pixel_row_next  = PW'(pr_inc);
            // End of image: wrap everything for the next frame.
            if (pr_inc >= w_eff) begin
                pixel_row_next    = '0;
                row_in_win_next   = '0;
                pooled_count_next = '0;
            end
        end else begin
            pixel_col_next = PW'(pc_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg    <= mpa_pkg::WIDTH_RESET;
            window_cfg_reg   <= mpa_pkg::WINDOW_RESET;
            pixel_col_reg    <= '0;
            pixel_row_reg    <= '0;
            col_in_win_reg   <= '0;
            row_in_win_reg   <= '0;
            window_col_reg   <= '0;
            pooled_count_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mpa_pkg::REG_IMAGE_WIDTH: begin
                    width_cfg_reg    <= cfg_data[mpa_pkg::WIDTH_CFG_BITS-1:0];
                    pixel_col_reg    <= '0;
                    pixel_row_reg    <= '0;
                    col_in_win_reg   <= '0;
                    row_in_win_reg   <= '0;
                    window_col_reg   <= '0;
                    pooled_count_reg <= '0;
                end
                mpa_pkg::REG_WINDOW_SIZE: begin
                    window_cfg_reg   <= cfg_data[mpa_pkg::WINDOW_CFG_BITS-1:0];
                    pixel_col_reg    <= '0;
                    pixel_row_reg    <= '0;
                    col_in_win_reg   <= '0;
                    row_in_win_reg   <= '0;
                    window_col_reg   <= '0;
                    pooled_count_reg <= '0;
                end
                default: begin
                    // Unknown register: drop the write.
                end
            endcase
        end else if (accept) begin
            pixel_col_reg    <= pixel_col_next;
            pixel_row_reg    <= pixel_row_next;
            col_in_win_reg   <= col_in_win_next;
            row_in_win_reg   <= row_in_win_next;
            window_col_reg   <= window_col_next;
            pooled_count_reg <= pooled_count_next;
        end
    end

endmodule

// ===== sv/mpa_rmw.sv =====
// Window store: read, compare against the running maximum, write back, with forwarding.
// Depends on mpa_pkg.
module mpa_rmw #(
    parameter int MAX_WIDTH   = mpa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW  = mpa_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF,
    localparam int PW = $clog2(MAX_WIDTH),
    localparam int RW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                accept,
    input  mpa_pkg::item_ctl_t                  ctl,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [PW-1:0]                       addr,
    input  logic [RW-1:0]                       cin,
    input  logic [RW-1:0]                       rin,
    input  logic [PW-1:0]                       base_row,
    input  logic [PW-1:0]                       base_col,
    input  logic [mpa_pkg::IDX_BITS-1:0]        pooled,
    output logic                                res_valid,
    output logic signed [SAMPLE_BITS-1:0]       res_value,
    output logic [PW-1:0]                       res_row,
    output logic [PW-1:0]                       res_col,
    output logic [mpa_pkg::IDX_BITS-1:0]        res_pooled,
    output logic                                res_last
);

    // Entry layout from the top: value, row of the maximum, column of the maximum.
    localparam int EB = SAMPLE_BITS + 2 * RW;

    logic [EB-1:0] mem [MAX_WIDTH];

    logic                          s1_valid_reg;
    mpa_pkg::item_ctl_t            s1_ctl_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [PW-1:0]                 s1_addr_reg;
    logic [RW-1:0]                 s1_cin_reg;
    logic [RW-1:0]                 s1_rin_reg;
    logic [PW-1:0]                 s1_base_row_reg;
    logic [PW-1:0]                 s1_base_col_reg;
    logic [mpa_pkg::IDX_BITS-1:0]  s1_pooled_reg;
    logic [EB-1:0]                 rd_data_reg;
    logic                          byp_hit_reg;
    logic [EB-1:0]                 byp_data_reg;

    logic [EB-1:0]                 cur;
    logic signed [SAMPLE_BITS-1:0] cur_val;
    logic [RW-1:0]                 cur_col;
    logic                          upd;
    logic [EB-1:0]                 new_entry;
    logic                          s1_wr;

    // The item just ahead writes on the same edge this item reads: take its entry.
    assign cur     = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign cur_val = cur[EB-1 -: SAMPLE_BITS];
    assign cur_col = cur[RW-1:0];

    // Ties keep the smaller column; equal columns keep the earlier row.
    assign upd = s1_ctl_reg.first_pix || (s1_sample_reg > cur_val) ||
                 ((s1_sample_reg == cur_val) && (s1_cin_reg < cur_col));
    assign new_entry = upd ? {s1_sample_reg, s1_rin_reg, s1_cin_reg} : cur;
    assign s1_wr     = s1_valid_reg && s1_ctl_reg.active;

    assign res_valid  = s1_wr && s1_ctl_reg.emit;
    assign res_value  = new_entry[EB-1 -: SAMPLE_BITS];
    assign res_row    = s1_base_row_reg + PW'(new_entry[2*RW-1 -: RW]);
    assign res_col    = s1_base_col_reg + PW'(new_entry[RW-1:0]);
    assign res_pooled = s1_pooled_reg;
    assign res_last   = s1_ctl_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= accept;
            byp_hit_reg  <= accept && s1_wr && (s1_addr_reg == addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (s1_wr) begin
                mem[s1_addr_reg] <= new_entry;
            end
            if (accept) begin
                rd_data_reg     <= mem[addr];
                byp_data_reg    <= new_entry;
                s1_ctl_reg      <= ctl;
                s1_sample_reg   <= sample;
                s1_addr_reg     <= addr;
                s1_cin_reg      <= cin;
                s1_rin_reg      <= rin;
                s1_base_row_reg <= base_row;
                s1_base_col_reg <= base_col;
                s1_pooled_reg   <= pooled;
            end
        end
    end

endmodule

// ===== sv/mpa_out.sv =====
// Flat index computation and the output register with its skid stage.
// Depends on mpa_pkg.
module mpa_out #(
    parameter int MAX_WIDTH   = mpa_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF,
    localparam int PW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                res_valid,
    input  logic signed [SAMPLE_BITS-1:0]       res_value,
    input  logic [PW-1:0]                       res_row,
    input  logic [PW-1:0]                       res_col,
    input  logic [mpa_pkg::IDX_BITS-1:0]        res_pooled,
    input  logic                                res_last,
    input  logic [WW-1:0]                       w_eff,
    output logic                                en,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic signed [SAMPLE_BITS-1:0]       m_value,
    output logic [mpa_pkg::IDX_BITS-1:0]        m_argmax,
    output logic [mpa_pkg::IDX_BITS-1:0]        m_pooled,
    output logic                                m_last
);

    localparam int PDW = (PW + WW + 1 > mpa_pkg::IDX_BITS) ? PW + WW + 1 : mpa_pkg::IDX_BITS;

    logic                          s2_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s2_value_reg;
    logic [PW-1:0]                 s2_row_reg;
    logic [PW-1:0]                 s2_col_reg;
    logic [mpa_pkg::IDX_BITS-1:0]  s2_pooled_reg;
    logic                          s2_last_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_value_reg;
    logic [mpa_pkg::IDX_BITS-1:0]  out_argmax_reg;
    logic [mpa_pkg::IDX_BITS-1:0]  out_pooled_reg;
    logic                          out_last_reg;

    logic                          skid_valid_reg;
    logic signed [SAMPLE_BITS-1:0] skid_value_reg;
    logic [mpa_pkg::IDX_BITS-1:0]  skid_argmax_reg;
    logic [mpa_pkg::IDX_BITS-1:0]  skid_pooled_reg;
    logic                          skid_last_reg;

    logic [PDW-1:0]                idx_full;
    logic [mpa_pkg::IDX_BITS-1:0]  argmax;
    logic                          out_free;
    logic                          load_new;

    // row * width + col, kept to the index width
    assign idx_full = PDW'(s2_row_reg) * PDW'(w_eff) + PDW'(s2_col_reg);
    assign argmax   = idx_full[mpa_pkg::IDX_BITS-1:0];

    assign en       = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign load_new = en && s2_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_argmax = out_argmax_reg;
    assign m_pooled = out_pooled_reg;
    assign m_last   = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                s2_valid_reg <= res_valid;
            end
            priority if (skid_valid_reg) begin
                if (out_free) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (load_new) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else begin
                if (out_free) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_value_reg  <= res_value;
            s2_row_reg    <= res_row;
            s2_col_reg    <= res_col;
            s2_pooled_reg <= res_pooled;
            s2_last_reg   <= res_last;
        end
        priority if (skid_valid_reg) begin
            if (out_free) begin
                out_value_reg  <= skid_value_reg;
                out_argmax_reg <= skid_argmax_reg;
                out_pooled_reg <= skid_pooled_reg;
                out_last_reg   <= skid_last_reg;
            end
        end else if (load_new) begin
            if (out_free) begin
                out_value_reg  <= s2_value_reg;
                out_argmax_reg <= argmax;
                out_pooled_reg <= s2_pooled_reg;
                out_last_reg   <= s2_last_reg;
            end else begin
                skid_value_reg  <= s2_value_reg;
                skid_argmax_reg <= argmax;
                skid_pooled_reg <= s2_pooled_reg;
                skid_last_reg   <= s2_last_reg;
            end
        end else begin
            // nothing new: hold
        end
    end

endmodule

// ===== sv/max_pool_2d_argmax_top.sv =====
// Streaming 2-D max pooling with argmax: one pixel per clock while s_tready is high, in
// raster order, one result per whole window, on m_tvalid once the window's last pixel has
// passed the s1, s2 and output registers. The rate is set by the read-modify-write loop on
// the one-row window store (one read and one write port, registered read, the previous
// item's write forwarded), which sustains one item per cycle.
// s_tready falls only while the skid stage holds a result that m_tready has not yet taken.
// A width or window size write restarts the raster counters; first_of_frame on s_tuser does too.
module max_pool_2d_argmax_top #(
    parameter int MAX_WIDTH   = mpa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW  = mpa_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 2 * mpa_pkg::IDX_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mpa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_TDATA_W-1:0]               s_tdata,   // sample
    input  logic                               s_tuser,   // first_of_frame
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,   // max_value, argmax_index, pooled_index
    output logic                               m_tlast    // last_of_frame
);

    localparam int PW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic                          en;
    logic                          accept;
    mpa_pkg::item_ctl_t            ctl;
    logic [PW-1:0]                 addr;
    logic [RW-1:0]                 cin;
    logic [RW-1:0]                 rin;
    logic [PW-1:0]                 base_row;
    logic [PW-1:0]                 base_col;
    logic [mpa_pkg::IDX_BITS-1:0]  pooled;
    logic [WW-1:0]                 w_eff;
    logic signed [SAMPLE_BITS-1:0] sample;

    logic                          res_valid;
    logic signed [SAMPLE_BITS-1:0] res_value;
    logic [PW-1:0]                 res_row;
    logic [PW-1:0]                 res_col;
    logic [mpa_pkg::IDX_BITS-1:0]  res_pooled;
    logic                          res_last;

    logic signed [SAMPLE_BITS-1:0] m_value;
    logic [mpa_pkg::IDX_BITS-1:0]  m_argmax;
    logic [mpa_pkg::IDX_BITS-1:0]  m_pooled;

    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign s_tready = en;
    assign m_tdata  = M_TDATA_W'({m_pooled, m_argmax, m_value});

    mpa_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (s_tvalid),
        .item_first (s_tuser),
        .en         (en),
        .accept     (accept),
        .ctl        (ctl),
        .addr       (addr),
        .cin        (cin),
        .rin        (rin),
        .base_row   (base_row),
        .base_col   (base_col),
        .pooled     (pooled),
        .w_eff      (w_eff)
    );

    mpa_rmw #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rmw (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .accept     (accept),
        .ctl        (ctl),
        .sample     (sample),
        .addr       (addr),
        .cin        (cin),
        .rin        (rin),
        .base_row   (base_row),
        .base_col   (base_col),
        .pooled     (pooled),
        .res_valid  (res_valid),
        .res_value  (res_value),
        .res_row    (res_row),
        .res_col    (res_col),
        .res_pooled (res_pooled),
        .res_last   (res_last)
    );

    mpa_out #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res_valid  (res_valid),
        .res_value  (res_value),
        .res_row    (res_row),
        .res_col    (res_col),
        .res_pooled (res_pooled),
        .res_last   (res_last),
        .w_eff      (w_eff),
        .en         (en),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_value    (m_value),
        .m_argmax   (m_argmax),
        .m_pooled   (m_pooled),
        .m_last     (m_tlast)
    );

endmodule

// ===== sv/mpa_checker.sv =====
// Port-level checks of the max pooling block, attached to the top level by bind.
// Depends on max_pool_2d_argmax_top_macros.svh.
`include "max_pool_2d_argmax_top_macros.svh"

module mpa_checker #(
    parameter int M_TDATA_W = 56
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // A stalled result keeps its item unchanged.
    `MPA_ASSERT(out_hold_chk, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // Reset empties the output side and opens the input side.
    `MPA_ASSERT_RST(rst_clear_chk, !aresetn |=> !m_tvalid && s_tready, "reset left a result or a stall")

    // The skid stage only fills while the sink stalls.
    `MPA_ASSERT(ready_follow_chk, m_tready |=> s_tready, "input stalled although the sink took items")

    // An input item may wait while the block is stalled, but only behind a pending result.
    `MPA_ASSERT(stall_cause_chk, !s_tready |-> m_tvalid, "input stalled with no result pending")

endmodule

bind max_pool_2d_argmax_top mpa_checker #(
    .M_TDATA_W (M_TDATA_W)
) u_mpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
